/* hdl/zbe_pkg.sv */
// Shared types, flag masks and a helper function for the Z80 base opcode execute unit.
package zbe_pkg;

   localparam logic [7:0] FL_S = 8'h80;
   localparam logic [7:0] FL_Z = 8'h40;
   localparam logic [7:0] FL_H = 8'h10;
   localparam logic [7:0] FL_P = 8'h04;
   localparam logic [7:0] FL_N = 8'h02;
   localparam logic [7:0] FL_C = 8'h01;
   localparam logic [7:0] FL_KEEP_XY = 8'h28;

   localparam logic [2:0] IDX_B = 3'd0;
   localparam logic [2:0] IDX_H = 3'd4;
   localparam logic [2:0] IDX_L = 3'd5;
   localparam logic [2:0] IDX_MEM = 3'd6;
   localparam logic [2:0] IDX_A = 3'd7;

   localparam logic [7:0] OP_EX_AF = 8'h08;
   localparam logic [7:0] OP_DJNZ = 8'h10;
   localparam logic [7:0] OP_JR = 8'h18;
   localparam logic [7:0] OP_HALT = 8'h76;
   localparam logic [7:0] OP_EXX = 8'hd9;
   localparam logic [7:0] OP_POP_AF = 8'hf1;
   localparam logic [7:0] OP_PUSH_AF = 8'hf5;

   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_ADC = 3'd1;
   localparam logic [2:0] ALU_SUB = 3'd2;
   localparam logic [2:0] ALU_SBC = 3'd3;
   localparam logic [2:0] ALU_AND = 3'd4;
   localparam logic [2:0] ALU_XOR = 3'd5;
   localparam logic [2:0] ALU_OR = 3'd6;
   localparam logic [2:0] ALU_CP = 3'd7;

   typedef struct packed {
      logic [7:0]  command;
      logic [7:0]  immediate_byte;
      logic [15:0] memory_read_data;
   } req_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic [3:0]  cycle_count;
      logic        write_enable;
      logic        write_is_word;
      logic [15:0] write_address;
      logic [15:0] write_data;
      logic [7:0]  flags_out;
      logic [7:0]  accumulator_out;
      logic        halted;
      logic        unsupported;
   } rsp_type;

   typedef struct packed {
      logic [7:0][7:0] main_regs;
      logic [7:0][7:0] alt_regs;
      logic [7:0]      flags;
      logic [7:0]      alt_flags;
      logic [15:0]     sp;
      logic [15:0]     pc;
      logic            halt;
   } arch_type;

   // Sign, zero and even parity of a byte, placed at their flag positions.
   function automatic logic [7:0] szp_bits(input logic [7:0] v);
      logic [7:0] f;
      f = 8'h00;
      if (v[7]) f = f | FL_S;
      if (v == 8'h00) f = f | FL_Z;
      if (!(^v)) f = f | FL_P;
      return f;
   endfunction

endpackage

/* hdl/zbe_exec.sv */
// Single-pass instruction decode and execute over the architectural state.
module zbe_exec
   import zbe_pkg::*;
(
   input  req_type  item,
   input  arch_type st,
   output arch_type nxt,
   output rsp_type  res
);

   logic [7:0]  cmd, imm, memb, a_val, alu_v, alu_r, idc_v, idc_r, idc_f, alu_f;
   logic [7:0]  rot_r, daa_f, f_cur;
   logic [15:0] pc, hl, next_pc, rel, wa, wd, pair_v, pair_r, daa_r;
   logic [16:0] hl_sum;
   logic [8:0]  s9;
   logic [3:0]  cyc;
   logic [2:0]  dst, src;
   logic [1:0]  p;
   logic        we, ww, bad, cin, take, cond_bit;

   assign cmd = item.command;
   assign imm = item.immediate_byte;
   assign memb = item.memory_read_data[7:0];
   assign dst = cmd[5:3];
   assign src = cmd[2:0];
   assign p = cmd[5:4];
   assign pc = st.pc;
   assign f_cur = st.flags;
   assign a_val = st.main_regs[IDX_A];
   assign hl = {st.main_regs[IDX_H], st.main_regs[IDX_L]};
   assign rel = pc + 16'd2 + {{8{imm[7]}}, imm};

   // 8-bit ALU
   always_comb begin
      if (cmd[7:6] == 2'b11) alu_v = imm;
      else if (src == IDX_MEM) alu_v = memb;
      else alu_v = st.main_regs[src];
      cin = ((dst == ALU_ADC) || (dst == ALU_SBC)) ? f_cur[0] : 1'b0;
      s9 = 9'd0;
      alu_r = 8'h00;
      alu_f = 8'h00;
      case (dst)
         ALU_ADD, ALU_ADC: begin
            s9 = {1'b0, a_val} + {1'b0, alu_v} + {8'd0, cin};
            alu_r = s9[7:0];
            alu_f = (f_cur & FL_KEEP_XY) | (szp_bits(alu_r) & (FL_S | FL_Z));
            if (((a_val ^ alu_v ^ alu_r) & 8'h10) != 8'h00) alu_f = alu_f | FL_H;
            if (((a_val ^ alu_r) & (alu_v ^ alu_r) & 8'h80) != 8'h00) alu_f = alu_f | FL_P;
            if (s9[8]) alu_f = alu_f | FL_C;
         end
         ALU_SUB, ALU_SBC, ALU_CP: begin
            s9 = {1'b0, a_val} - {1'b0, alu_v} - {8'd0, cin};
            alu_r = s9[7:0];
            alu_f = (f_cur & FL_KEEP_XY) | (szp_bits(alu_r) & (FL_S | FL_Z)) | FL_N;
            if (((a_val ^ alu_v ^ alu_r) & 8'h10) != 8'h00) alu_f = alu_f | FL_H;
            if (((a_val ^ alu_v) & (a_val ^ alu_r) & 8'h80) != 8'h00) alu_f = alu_f | FL_P;
            if (s9[8]) alu_f = alu_f | FL_C;
            if (dst == ALU_CP) alu_r = a_val;
         end
         ALU_AND: begin
            alu_r = a_val & alu_v;
            alu_f = (f_cur & FL_KEEP_XY) | szp_bits(alu_r) | FL_H;
         end
         ALU_XOR: begin
            alu_r = a_val ^ alu_v;
            alu_f = (f_cur & FL_KEEP_XY) | szp_bits(alu_r);
         end
         default: begin
            alu_r = a_val | alu_v;
            alu_f = (f_cur & FL_KEEP_XY) | szp_bits(alu_r);
         end
      endcase
   end

   // 8-bit INC and DEC, carry kept
   always_comb begin
      idc_v = (dst == IDX_MEM) ? memb : st.main_regs[dst];
      if (src == 3'd4) begin
         idc_r = idc_v + 8'd1;
         idc_f = (f_cur & (FL_KEEP_XY | FL_C)) | (szp_bits(idc_r) & (FL_S | FL_Z));
         if (idc_v[3:0] == 4'hf) idc_f = idc_f | FL_H;
         if (idc_v == 8'h7f) idc_f = idc_f | FL_P;
      end else begin
         idc_r = idc_v - 8'd1;
         idc_f = (f_cur & (FL_KEEP_XY | FL_C)) | (szp_bits(idc_r) & (FL_S | FL_Z)) | FL_N;
         if (idc_v[3:0] == 4'h0) idc_f = idc_f | FL_H;
         if (idc_v == 8'h80) idc_f = idc_f | FL_P;
      end
   end

   // Decimal adjust; on addition the high step looks at the value after the low step
   always_comb begin
      daa_r = {8'h00, a_val};
      daa_f = f_cur;
      if ((f_cur & FL_N) != 8'h00) begin
         if (a_val[3:0] >= 4'ha || (f_cur & FL_H) != 8'h00) begin
            if (a_val[3:0] >= 4'h6) daa_f = daa_f & ~FL_H;
            daa_r = (daa_r - 16'h0006) & 16'h00ff;
         end
         if (a_val > 8'h99 || (f_cur & FL_C) != 8'h00) daa_r = daa_r - 16'h0160;
      end else begin
         if (a_val[3:0] >= 4'ha || (f_cur & FL_H) != 8'h00) begin
            daa_f = (daa_f & ~FL_H) | ((a_val[3:0] >= 4'ha) ? FL_H : 8'h00);
            daa_r = daa_r + 16'h0006;
         end
         if (daa_r >= 16'h00a0 || (f_cur & FL_C) != 8'h00) daa_r = daa_r + 16'h0060;
      end
      daa_f = (daa_f & ~(FL_S | FL_Z | FL_P | FL_C)) | szp_bits(daa_r[7:0])
            | ((daa_r[15:8] != 8'h00) ? FL_C : 8'h00);
   end

   always_comb begin
      case (dst[1:0])
         2'd0: rot_r = {a_val[6:0], a_val[7]};
         2'd1: rot_r = {a_val[0], a_val[7:1]};
         2'd2: rot_r = {a_val[6:0], f_cur[0]};
         default: rot_r = {f_cur[0], a_val[7:1]};
      endcase
   end

   always_comb begin
      pair_v = (p == 2'd3) ? st.sp : {st.main_regs[{p, 1'b0}], st.main_regs[{p, 1'b1}]};
      pair_r = cmd[3] ? (pair_v - 16'd1) : (pair_v + 16'd1);
      hl_sum = {1'b0, hl} + {1'b0, pair_v};
      cond_bit = cmd[4] ? f_cur[0] : f_cur[6];
      take = cmd[3] ? cond_bit : !cond_bit;
   end

   always_comb begin
      nxt = st;
      next_pc = pc + 16'd1;
      cyc = 4'd4;
      we = 1'b0;
      ww = 1'b0;
      wa = 16'h0000;
      wd = 16'h0000;
      bad = 1'b0;
      if (cmd[7:6] == 2'b01) begin
         if (cmd == OP_HALT) begin
            nxt.halt = 1'b1;
            cyc = 4'd7;
         end else if (dst == IDX_MEM) begin
            we = 1'b1;
            wa = hl;
            wd = {8'h00, st.main_regs[src]};
            cyc = 4'd7;
         end else if (src == IDX_MEM) begin
            nxt.main_regs[dst] = memb;
            cyc = 4'd7;
         end else begin
            nxt.main_regs[dst] = st.main_regs[src];
         end
      end else if (cmd[7:6] == 2'b10) begin
         nxt.main_regs[IDX_A] = alu_r;
         nxt.flags = alu_f;
         cyc = (src == IDX_MEM) ? 4'd7 : 4'd4;
      end else if (cmd[7:6] == 2'b11 && src == 3'd6) begin
         nxt.main_regs[IDX_A] = alu_r;
         nxt.flags = alu_f;
         cyc = 4'd7;
         next_pc = pc + 16'd2;
      end else if (cmd[7:6] == 2'b11 && src == 3'd7) begin
         nxt.sp = st.sp - 16'd2;
         we = 1'b1;
         ww = 1'b1;
         wa = st.sp - 16'd2;
         wd = pc + 16'd1;
         next_pc = {10'd0, dst, 3'd0};
         cyc = 4'd11;
      end else if (cmd[7:6] == 2'b00) begin
         case (src)
            3'd0: begin
               if (cmd == OP_EX_AF) begin
                  nxt.flags = st.alt_flags;
                  nxt.alt_flags = st.flags;
                  nxt.main_regs[IDX_A] = st.alt_regs[IDX_A];
                  nxt.alt_regs[IDX_A] = st.main_regs[IDX_A];
               end else if (cmd == OP_DJNZ) begin
                  nxt.main_regs[IDX_B] = st.main_regs[IDX_B] - 8'd1;
                  if (st.main_regs[IDX_B] != 8'd1) begin
                     next_pc = rel;
                     cyc = 4'd13;
                  end else begin
                     next_pc = pc + 16'd2;
                     cyc = 4'd8;
                  end
               end else if (cmd == OP_JR) begin
                  next_pc = rel;
                  cyc = 4'd12;
               end else if (cmd[5]) begin
                  if (take) begin
                     next_pc = rel;
                     cyc = 4'd12;
                  end else begin
                     next_pc = pc + 16'd2;
                     cyc = 4'd7;
                  end
               end else begin
                  bad = 1'b1;
               end
            end
            3'd1: begin
               if (cmd[3]) begin
                  nxt.flags = (f_cur & ~(FL_H | FL_N | FL_C))
                            | (hl_sum[12] ^ hl[12] ^ pair_v[12] ? FL_H : 8'h00)
                            | (hl_sum[16] ? FL_C : 8'h00);
                  nxt.main_regs[IDX_H] = hl_sum[15:8];
                  nxt.main_regs[IDX_L] = hl_sum[7:0];
                  cyc = 4'd11;
               end else begin
                  bad = 1'b1;
               end
            end
            3'd3: begin
               if (p == 2'd3) nxt.sp = pair_r;
               else begin
                  nxt.main_regs[{p, 1'b0}] = pair_r[15:8];
                  nxt.main_regs[{p, 1'b1}] = pair_r[7:0];
               end
               cyc = 4'd6;
            end
            3'd4, 3'd5: begin
               nxt.flags = idc_f;
               if (dst == IDX_MEM) begin
                  we = 1'b1;
                  wa = hl;
                  wd = {8'h00, idc_r};
                  cyc = 4'd11;
               end else begin
                  nxt.main_regs[dst] = idc_r;
               end
            end
            3'd7: begin
               if (!dst[2]) begin
                  nxt.main_regs[IDX_A] = rot_r;
                  nxt.flags = (f_cur & ~(FL_H | FL_N | FL_C))
                            | {7'd0, dst[0] ? a_val[0] : a_val[7]};
               end else if (dst == 3'd4) begin
                  nxt.main_regs[IDX_A] = daa_r[7:0];
                  nxt.flags = daa_f;
               end else if (dst == 3'd5) begin
                  nxt.main_regs[IDX_A] = ~a_val;
                  nxt.flags = f_cur | FL_H | FL_N;
               end else if (dst == 3'd6) begin
                  nxt.flags = (f_cur & ~(FL_H | FL_N)) | FL_C;
               end else begin
                  nxt.flags = (f_cur & ~(FL_H | FL_N | FL_C))
                            | (f_cur[0] ? FL_H : FL_C);
               end
            end
            default: bad = 1'b1;
         endcase
      end else if (cmd == OP_EXX) begin
         for (int i = 0; i < 6; i++) begin
            nxt.main_regs[3'(i)] = st.alt_regs[3'(i)];
            nxt.alt_regs[3'(i)] = st.main_regs[3'(i)];
         end
      end else if (cmd == OP_POP_AF) begin
         nxt.flags = item.memory_read_data[7:0];
         nxt.main_regs[IDX_A] = item.memory_read_data[15:8];
         nxt.sp = st.sp + 16'd2;
         cyc = 4'd10;
      end else if (cmd == OP_PUSH_AF) begin
         nxt.sp = st.sp - 16'd2;
         we = 1'b1;
         ww = 1'b1;
         wa = st.sp - 16'd2;
         wd = {a_val, f_cur};
         cyc = 4'd11;
      end else begin
         bad = 1'b1;
      end

      // Drop every effect of an unknown opcode
      if (bad) begin
         nxt = st;
         next_pc = pc;
         cyc = 4'd0;
         we = 1'b0;
         ww = 1'b0;
         wa = 16'h0000;
         wd = 16'h0000;
      end
      nxt.pc = next_pc;

      res.next_pc = next_pc;
      res.cycle_count = cyc;
      res.write_enable = we;
      res.write_is_word = ww;
      res.write_address = wa;
      res.write_data = wd;
      res.flags_out = nxt.flags;
      res.accumulator_out = nxt.main_regs[IDX_A];
      res.halted = nxt.halt;
      res.unsupported = bad;
   end

endmodule

/* hdl/z80_base_opcode_execute_unit.sv */
// Top level: input register, architectural state, execute stage and result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data (command, immediate, memory data)
//   rsp      out        rsp_valid / rsp_stall  rsp_data (next PC, cycles, write, flags, A)
//
// An item is captured in the input register and is then executed in a single pass over
// the register file into the result register; one item is taken per cycle while the
// result is not stalled.
// Reset clears both banks, the flags, SP, PC, the halt flag and both valid bits.
// A stalled result holds in the result register; the input register holds behind it.
module z80_base_opcode_execute_unit
   import zbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     in_valid_ff, in_valid_in, rsp_valid_ff, rsp_valid_in, fire;
   req_type  in_data_ff;
   rsp_type  rsp_data_ff, exec_res;
   arch_type state_ff, exec_nxt;

   zbe_exec u_exec (
      .item (in_data_ff),
      .st   (state_ff),
      .nxt  (exec_nxt),
      .res  (exec_res)
   );

   assign fire = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) state_ff <= exec_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_data_ff <= req_data;
      if (fire) rsp_data_ff <= exec_res;
   end

   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      state_ff.halt |=> state_ff.halt)
      else $error("halt flag dropped without reset");

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled with no item held");

   a_fire_gives_result : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("executed item produced no result");

   a_pc_tracks_result : assert property (@(posedge clock) disable iff (reset)
      fire |=> state_ff.pc == rsp_data_ff.next_pc)
      else $error("PC differs from reported next PC");

endmodule
